// File: rtl/assert_macros.svh
// assertion macros shared by the allocator rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define BBA_ASSERT_IMP(name, clk, rst, pre, post) \
   name: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("%m: implication failed");

// next-cycle implication
`define BBA_ASSERT_NXT(name, clk, rst, pre, post) \
   name: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("%m: next-cycle implication failed");

`endif

// File: rtl/bba_pkg.sv
// package with types and constants of the bitmap block allocator
`timescale 1ns / 1ps
package bba_pkg;

   localparam int DEF_BLOCK_COUNT = 4096;
   localparam int DEF_BLOCK_BYTES = 64;
   localparam int WORD_BITS       = 32;
   localparam int BIT_W           = $clog2(WORD_BITS);
   localparam int OFS_W           = 20;
   localparam int STATUS_W        = 2;
   localparam int INDEX_W         = 12;

   localparam logic KIND_ALLOC = 1'b0;
   localparam logic KIND_FREE  = 1'b1;

   typedef enum logic [STATUS_W-1:0] {
      STS_ALLOCATED = 2'd0,
      STS_FULL      = 2'd1,
      STS_FREED     = 2'd2,
      STS_INVALID   = 2'd3
   } status_type;

   typedef struct packed {
      logic clear;
      logic accept;
      logic div1;
      logic div2;
      logic read;
      logic modify;
      logic load_out;
   } cmd_type;

   typedef struct packed {
      logic clear_last;
      logic in_alloc;
      logic in_any_free;
      logic in_neg;
      logic div_ok;
      logic out_free;
   } sts_type;

endpackage

// File: rtl/bba_channels.sv
// request and response channel interfaces of the allocator
`timescale 1ns / 1ps
interface bba_req_if import bba_pkg::*; ();
   logic                    valid;
   logic                    ready;
   logic                    kind;
   logic signed [OFS_W-1:0] free_offset;

   modport source (output valid, output kind, output free_offset, input ready);
   modport sink   (input valid, input kind, input free_offset, output ready);
endinterface

interface bba_rsp_if import bba_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [STATUS_W-1:0] status;
   logic [INDEX_W-1:0]  block_index;

   modport source (output valid, output status, output block_index, input ready);
   modport sink   (input valid, input status, input block_index, output ready);
endinterface

// File: rtl/bitmap_block_allocator.sv
// top level of the bitmap fixed-size block allocator, first fit
// allocate: accept, bitmap read, read-modify-write, output load
// free: the same, with the reciprocal divide of the byte offset between accept and read
// pool full or negative offset: accept, output load; offset past the pool or
// misaligned: accept, divide, output load. reset: synchronous; a clearing pass
// of one bitmap word per cycle runs after reset, during which no request is taken
`timescale 1ns / 1ps
module bitmap_block_allocator import bba_pkg::*; #(
   parameter int BLOCK_COUNT = DEF_BLOCK_COUNT,
   parameter int BLOCK_BYTES = DEF_BLOCK_BYTES
) (
   input logic      clock,
   input logic      reset,
   bba_req_if.sink  req_if,
   bba_rsp_if.source rsp_if
);

   cmd_type cmd;
   sts_type sts;
   logic    req_ready;

   bba_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .req_ready (req_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   bba_dpath #(
      .BLOCK_COUNT (BLOCK_COUNT),
      .BLOCK_BYTES (BLOCK_BYTES)
   ) u_dpath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .sts             (sts),
      .req_kind        (req_if.kind),
      .req_free_offset (req_if.free_offset),
      .rsp_ready       (rsp_if.ready),
      .rsp_valid       (rsp_if.valid),
      .rsp_status      (rsp_if.status),
      .rsp_block_index (rsp_if.block_index)
   );

   assign req_if.ready = req_ready;

endmodule

// File: rtl/bba_ctrl.sv
// controller state machine of the allocator
`timescale 1ns / 1ps
`include "assert_macros.svh"
module bba_ctrl import bba_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  sts_type sts,
   output cmd_type cmd
);

   typedef enum logic [6:0] {
      ST_CLEAR  = 7'b0000001,
      ST_IDLE   = 7'b0000010,
      ST_DIV1   = 7'b0000100,
      ST_DIV2   = 7'b0001000,
      ST_READ   = 7'b0010000,
      ST_MODIFY = 7'b0100000,
      ST_DONE   = 7'b1000000
   } state_type;

   state_type state_ff;
   state_type state_in;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: begin
            if (sts.clear_last) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (req_valid) begin
               if (sts.in_alloc) begin
                  state_in = sts.in_any_free ? ST_READ : ST_DONE;
               end else begin
                  state_in = sts.in_neg ? ST_DONE : ST_DIV1;
               end
            end
         end
         ST_DIV1: begin
            state_in = ST_DIV2;
         end
         ST_DIV2: begin
            state_in = sts.div_ok ? ST_READ : ST_DONE;
         end
         ST_READ: begin
            state_in = ST_MODIFY;
         end
         ST_MODIFY: begin
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (sts.out_free) state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_ready    = (state_ff == ST_IDLE);
   assign cmd.clear    = (state_ff == ST_CLEAR);
   assign cmd.accept   = (state_ff == ST_IDLE) && req_valid;
   assign cmd.div1     = (state_ff == ST_DIV1);
   assign cmd.div2     = (state_ff == ST_DIV2);
   assign cmd.read     = (state_ff == ST_READ);
   assign cmd.modify   = (state_ff == ST_MODIFY);
   assign cmd.load_out = (state_ff == ST_DONE) && sts.out_free;

   `BBA_ASSERT_NXT(a_busy_after_accept, clock, reset, cmd.accept, state_ff != ST_IDLE)

endmodule

// File: rtl/bba_dpath.sv
// datapath of the allocator: bitmap memory, full-word summary, offset divide, output register
`timescale 1ns / 1ps
`include "assert_macros.svh"
module bba_dpath import bba_pkg::*; #(
   parameter int BLOCK_COUNT = DEF_BLOCK_COUNT,
   parameter int BLOCK_BYTES = DEF_BLOCK_BYTES
) (
   input  logic                    clock,
   input  logic                    reset,
   input  cmd_type                 cmd,
   output sts_type                 sts,
   input  logic                    req_kind,
   input  logic signed [OFS_W-1:0] req_free_offset,
   input  logic                    rsp_ready,
   output logic                    rsp_valid,
   output logic [STATUS_W-1:0]     rsp_status,
   output logic [INDEX_W-1:0]      rsp_block_index
);

   localparam int MAP_WORDS = (BLOCK_COUNT + WORD_BITS - 1) / WORD_BITS;
   localparam int WORD_AW   = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
   localparam int IDX_W     = WORD_AW + BIT_W;
   localparam int MAG_W     = OFS_W - 1;
   localparam int LOG2B     = $clog2(BLOCK_BYTES);
   localparam int SHIFT     = MAG_W + LOG2B;
   localparam int RECIP_W   = MAG_W + 1;
   localparam int PROD_W    = MAG_W + RECIP_W;
   localparam logic [63:0] RECIP_FULL = (64'd1 << SHIFT) / 64'(BLOCK_BYTES);
   localparam logic [RECIP_W-1:0] RECIP = RECIP_FULL[RECIP_W-1:0];
   localparam logic [MAG_W-1:0] BYTES_M = MAG_W'(BLOCK_BYTES);
   localparam logic [MAG_W-1:0] COUNT_M = MAG_W'(BLOCK_COUNT);
   localparam int LAST_BITS = BLOCK_COUNT - WORD_BITS * (MAP_WORDS - 1);
   localparam logic [WORD_BITS:0] LAST_ONES = (33'd1 << LAST_BITS) - 33'd1;
   localparam logic [WORD_BITS-1:0] PAD_MASK = ~LAST_ONES[WORD_BITS-1:0];
   localparam logic [WORD_AW-1:0] LAST_WORD = WORD_AW'(MAP_WORDS - 1);

   logic [WORD_BITS-1:0] mem [MAP_WORDS];

   logic                 kind_ff;
   logic [MAG_W-1:0]     ofs_ff;
   logic [MAG_W-1:0]     q0_ff;
   logic [WORD_AW-1:0]   word_ff;
   logic [BIT_W-1:0]     bit_ff;
   logic [WORD_BITS-1:0] rd_ff;
   status_type           res_status_ff;
   logic [IDX_W-1:0]     res_idx_ff;
   logic [MAP_WORDS-1:0] full_ff;
   logic [WORD_AW-1:0]   clr_addr_ff;
   logic                 out_valid_ff;
   logic                 out_valid_in;
   status_type           out_status_ff;
   logic [IDX_W-1:0]     out_idx_ff;

   logic [WORD_AW-1:0]   first_word;
   logic [PROD_W-1:0]    recip_prod;
   logic [MAG_W-1:0]     back_prod;
   logic [MAG_W-1:0]     rem0;
   logic                 rem_over;
   logic [MAG_W-1:0]     quot;
   logic [MAG_W-1:0]     rem;
   logic [WORD_BITS-1:0] masked;
   logic [BIT_W-1:0]     first_bit;
   logic [BIT_W-1:0]     sel_bit;
   logic [WORD_BITS-1:0] sel_mask;
   logic [WORD_BITS-1:0] new_word;
   logic                 we;
   logic [WORD_AW-1:0]   wa;
   logic [WORD_BITS-1:0] wd;

   // lowest word with a free block
   always_comb begin
      first_word = '0;
      for (int w = MAP_WORDS - 1; w >= 0; w--) begin
         if (!full_ff[w]) first_word = WORD_AW'(w);
      end
   end

   // offset / block size by reciprocal, then one correction step
   assign recip_prod = PROD_W'(ofs_ff) * PROD_W'(RECIP);
   assign back_prod  = MAG_W'(PROD_W'(q0_ff) * PROD_W'(BYTES_M));
   assign rem0       = ofs_ff - back_prod;
   assign rem_over   = (rem0 >= BYTES_M);
   assign quot       = rem_over ? (q0_ff + MAG_W'(1)) : q0_ff;
   assign rem        = rem_over ? (rem0 - BYTES_M) : rem0;

   // bits past the pool end count as used
   assign masked = rd_ff | ((word_ff == LAST_WORD) ? PAD_MASK : '0);

   always_comb begin
      first_bit = '0;
      for (int b = WORD_BITS - 1; b >= 0; b--) begin
         if (!masked[b]) first_bit = BIT_W'(b);
      end
   end

   assign sel_bit  = (kind_ff == KIND_ALLOC) ? first_bit : bit_ff;
   assign sel_mask = {{(WORD_BITS-1){1'b0}}, 1'b1} << sel_bit;
   assign new_word = (kind_ff == KIND_ALLOC) ? (rd_ff | sel_mask) : (rd_ff & ~sel_mask);

   assign we = cmd.clear || cmd.modify;
   assign wa = cmd.clear ? clr_addr_ff : word_ff;
   assign wd = cmd.clear ? '0 : new_word;

   always_ff @(posedge clock) begin
      if (we) mem[wa] <= wd;
      if (cmd.read) rd_ff <= mem[word_ff];
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         kind_ff       <= req_kind;
         ofs_ff        <= req_free_offset[MAG_W-1:0];
         word_ff       <= first_word;
         res_status_ff <= (req_kind == KIND_ALLOC) ? STS_FULL : STS_INVALID;
         res_idx_ff    <= '0;
      end
      if (cmd.div1) begin
         q0_ff <= MAG_W'(recip_prod >> SHIFT);
      end
      if (cmd.div2) begin
         word_ff <= WORD_AW'(quot >> BIT_W);
         bit_ff  <= quot[BIT_W-1:0];
      end
      if (cmd.modify) begin
         res_status_ff <= (kind_ff == KIND_ALLOC) ? STS_ALLOCATED : STS_FREED;
         res_idx_ff    <= {word_ff, sel_bit};
      end
      if (cmd.load_out) begin
         out_status_ff <= res_status_ff;
         out_idx_ff    <= res_idx_ff;
      end
   end

   assign out_valid_in = cmd.load_out ? 1'b1 : (rsp_ready ? 1'b0 : out_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         full_ff      <= '0;
         clr_addr_ff  <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
         if (cmd.clear) clr_addr_ff <= clr_addr_ff + WORD_AW'(1);
         if (cmd.modify) begin
            full_ff[word_ff] <= (kind_ff == KIND_ALLOC) ? (&(new_word | masked)) : 1'b0;
         end
      end
   end

   assign sts.clear_last  = (clr_addr_ff == LAST_WORD);
   assign sts.in_alloc    = (req_kind == KIND_ALLOC);
   assign sts.in_any_free = ~(&full_ff);
   assign sts.in_neg      = req_free_offset[OFS_W-1];
   assign sts.div_ok      = (rem == '0) && (quot < COUNT_M);
   assign sts.out_free    = !out_valid_ff || rsp_ready;

   assign rsp_valid       = out_valid_ff;
   assign rsp_status      = out_status_ff;
   assign rsp_block_index = INDEX_W'(out_idx_ff);

   `BBA_ASSERT_IMP(a_no_overwrite, clock, reset, cmd.load_out, !out_valid_ff || rsp_ready)
   `BBA_ASSERT_IMP(a_alloc_has_room, clock, reset, cmd.modify && (kind_ff == KIND_ALLOC),
                   !(&masked))

endmodule

// File: test/tb.sv
// self-checking testbench for the first-fit bitmap block allocator
`timescale 1ns / 1ps
module tb import bba_pkg::*; ();

   localparam int MAP_WORDS  = (DEF_BLOCK_COUNT + WORD_BITS - 1) / WORD_BITS;
   localparam int POOL_BYTES = DEF_BLOCK_COUNT * DEF_BLOCK_BYTES;
   localparam int RANDOM_REQS = 1264;
   localparam int PHASE_REQS  = RANDOM_REQS / 4;

   typedef struct packed {
      status_type         status;
      logic [INDEX_W-1:0] block_index;
   } outcome_type;

   class alloc_scoreboard;
      logic [WORD_BITS-1:0] used_words[MAP_WORDS];
      outcome_type          outcome_q[$];
      int                   errors;
      int                   seen[4];

      function new();
         foreach (used_words[w]) used_words[w] = '0;
         errors = 0;
         foreach (seen[s]) seen[s] = 0;
      endfunction

      // first-fit allocate or free on the shadow map, queue the outcome
      function outcome_type note_request(logic kind, logic signed [OFS_W-1:0] ofs);
         outcome_type o;
         int          w;
         int          b;
         int          d;
         int          blk;
         o.status      = STS_FULL;
         o.block_index = '0;
         if (kind == KIND_ALLOC) begin
            for (w = 0; w < MAP_WORDS; w++) begin
               if (used_words[w] != '1) break;
            end
            if (w < MAP_WORDS) begin
               for (b = 0; b < WORD_BITS; b++) begin
                  if (!used_words[w][b]) break;
               end
               used_words[w][b] = 1'b1;
               o.status      = STS_ALLOCATED;
               o.block_index = INDEX_W'(w * WORD_BITS + b);
            end
         end else begin
            d = ofs;
            if (d < 0 || d >= POOL_BYTES || d % DEF_BLOCK_BYTES != 0) begin
               o.status = STS_INVALID;
            end else begin
               blk = d / DEF_BLOCK_BYTES;
               used_words[blk / WORD_BITS][blk % WORD_BITS] = 1'b0;
               o.status      = STS_FREED;
               o.block_index = INDEX_W'(blk);
            end
         end
         outcome_q.push_back(o);
         return o;
      endfunction

      function void check_response(logic [STATUS_W-1:0] status,
                                   logic [INDEX_W-1:0] block_index);
         outcome_type o;
         if (outcome_q.size() == 0) begin
            $error("response with nothing outstanding: status %0d block_index %0d",
                   status, block_index);
            errors++;
            return;
         end
         o = outcome_q.pop_front();
         seen[o.status]++;
         if (status !== o.status) begin
            $error("status: expected %0d, got %0d", o.status, status);
            errors++;
         end
         if (block_index !== o.block_index) begin
            $error("block_index: expected %0d, got %0d", o.block_index, block_index);
            errors++;
         end
      endfunction
   endclass

   logic clock;
   logic reset;

   bba_req_if req_ch ();
   bba_rsp_if rsp_ch ();

   bitmap_block_allocator uut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_ch),
      .rsp_if (rsp_ch)
   );

   alloc_scoreboard board;
   int              send_idle_pct;
   int              recv_stall_pct;
   int              in_use_q[$];
   int              total_reqs;

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   initial begin
      #10_000_000;
      $display("tb: FAIL");
      $finish;
   end

   // response side: check every accepted response, stall at random
   initial begin
      rsp_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (reset === 1'b0 && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1)
            board.check_response(rsp_ch.status, rsp_ch.block_index);
         rsp_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   task automatic send_request(input logic kind, input logic signed [OFS_W-1:0] ofs,
                               output outcome_type predicted);
      while ($urandom_range(99) < send_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid       <= 1'b1;
      req_ch.kind        <= kind;
      req_ch.free_offset <= ofs;
      @(posedge clock);
      while (req_ch.ready !== 1'b1) @(posedge clock);
      predicted = board.note_request(kind, ofs);
   endtask

   // send one request and keep the list of blocks in use current
   task automatic issue(input logic kind, input logic signed [OFS_W-1:0] ofs);
      outcome_type o;
      int          hits[$];
      send_request(kind, ofs, o);
      total_reqs++;
      if (o.status == STS_ALLOCATED) begin
         in_use_q.push_back(int'(o.block_index));
      end else if (o.status == STS_FREED) begin
         hits = in_use_q.find_first_index(x) with (x == int'(o.block_index));
         if (hits.size() != 0) in_use_q.delete(hits[0]);
      end
   endtask

   task automatic drain_responses();
      req_ch.valid <= 1'b0;
      do @(posedge clock); while (board.outcome_q.size() != 0);
   endtask

   function automatic logic signed [OFS_W-1:0] block_offset(int blk);
      return OFS_W'(blk * DEF_BLOCK_BYTES);
   endfunction

   task automatic issue_random();
      int r;
      int blk;
      r = $urandom_range(99);
      if (r < 50 || (r < 75 && in_use_q.size() == 0)) begin
         issue(KIND_ALLOC, OFS_W'($urandom));
      end else if (r < 75) begin
         blk = in_use_q[$urandom_range(in_use_q.size() - 1)];
         issue(KIND_FREE, block_offset(blk));
      end else if (r < 82) begin
         issue(KIND_FREE, block_offset($urandom_range(DEF_BLOCK_COUNT - 1)));
      end else if (r < 86) begin
         issue(KIND_FREE, OFS_W'(-int'($urandom_range(1, 1 << (OFS_W - 1)))));
      end else if (r < 90) begin
         issue(KIND_FREE, OFS_W'($urandom_range(POOL_BYTES, (1 << (OFS_W - 1)) - 1)));
      end else if (r < 95) begin
         blk = $urandom_range(DEF_BLOCK_COUNT - 1);
         issue(KIND_FREE, OFS_W'(blk * DEF_BLOCK_BYTES +
                                 $urandom_range(1, DEF_BLOCK_BYTES - 1)));
      end else begin
         issue(KIND_FREE, OFS_W'($urandom));
      end
   endtask

   initial begin
      int n;
      int blk;
      board              = new();
      total_reqs         = 0;
      send_idle_pct      = 0;
      recv_stall_pct     = 0;
      reset              <= 1'b1;
      req_ch.valid       <= 1'b0;
      req_ch.kind        <= KIND_ALLOC;
      req_ch.free_offset <= '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // directed corners
      issue(KIND_ALLOC, '0);
      issue(KIND_ALLOC, '0);
      issue(KIND_ALLOC, '0);
      issue(KIND_FREE, block_offset(1));
      issue(KIND_ALLOC, '0);
      issue(KIND_FREE, block_offset(1));
      issue(KIND_FREE, block_offset(1));             // already free
      issue(KIND_FREE, '1);                          // -1
      issue(KIND_FREE, {1'b1, {(OFS_W - 1){1'b0}}}); // most negative
      issue(KIND_FREE, {1'b0, {(OFS_W - 1){1'b1}}}); // most positive
      issue(KIND_FREE, OFS_W'(POOL_BYTES));          // first byte past the pool
      issue(KIND_FREE, block_offset(DEF_BLOCK_COUNT - 1));
      issue(KIND_FREE, OFS_W'(POOL_BYTES - 1));
      issue(KIND_FREE, OFS_W'(1));
      issue(KIND_FREE, OFS_W'(DEF_BLOCK_BYTES / 2));
      issue(KIND_FREE, '0);
      issue(KIND_ALLOC, '1);                         // offset ignored on allocate
      issue(KIND_FREE, OFS_W'(-DEF_BLOCK_BYTES));
      issue(KIND_FREE, OFS_W'(((1 << (OFS_W - 1)) - 1) / DEF_BLOCK_BYTES * DEF_BLOCK_BYTES));
      issue(KIND_ALLOC, '0);
      drain_responses();

      // random mix, rotating through the idle patterns
      for (n = 0; n < RANDOM_REQS; n++) begin
         if (n % PHASE_REQS == 0) begin
            case ((n / PHASE_REQS) % 4)
               0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
               1: begin send_idle_pct = 66; recv_stall_pct = 0;  end
               2: begin send_idle_pct = 0;  recv_stall_pct = 66; end
               default: begin send_idle_pct = 9; recv_stall_pct = 9; end
            endcase
         end
         issue_random();
         if ($urandom_range(49) == 0) drain_responses();
      end

      // free blocks in use and allocate again right after
      send_idle_pct  = 9;
      recv_stall_pct = 9;
      repeat (8) begin
         blk = in_use_q[$urandom_range(in_use_q.size() - 1)];
         issue(KIND_FREE, block_offset(blk));
         issue(KIND_ALLOC, OFS_W'($urandom));
         issue(KIND_ALLOC, OFS_W'($urandom));
      end
      send_idle_pct  = 66;
      recv_stall_pct = 66;
      repeat (40) issue_random();

      drain_responses();
      repeat (20) @(posedge clock);

      $display("%0d requests: %0d allocated, %0d pool full, %0d freed, %0d rejected",
               total_reqs, board.seen[STS_ALLOCATED], board.seen[STS_FULL],
               board.seen[STS_FREED], board.seen[STS_INVALID]);
      $display("idle patterns none/sender/receiver/both covered, free and reallocate pairs");
      if (board.errors == 0 && board.outcome_q.size() == 0) begin
         $display("tb: PASS");
      end else begin
         $display("tb: FAIL");
      end
      $finish;
   end
endmodule
